// ===== rtl/assert_macros.svh =====
// assertion macros for the skyline allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define SKY_ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("skyline allocator assertion failed");

// concurrent assertion on the default clock and reset of the block
`define SKY_ASSERT(lbl, prop) `SKY_ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/sky_pkg.sv =====
// shared types, codes and defaults of the skyline atlas allocator
package sky_pkg;

  localparam int ATLAS_SIZE_DEF = 256;

  localparam int RECT_W = 9;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [STAT_W-1:0] ST_PLACED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOROOM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLEARED = 2'd2;

  typedef struct packed {
    logic              load;
    logic              clr_step;
    logic              p1_step;
    logic              p2_init;
    logic              p2_step;
    logic              wr_init;
    logic              wr_step;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
  } sky_cmd_t;

  typedef struct packed {
    logic req_clear;
    logic req_bad;
    logic idx_top;
    logic idx_zero;
    logic wr_end;
    logic fits;
  } sky_stat_t;

endpackage

// ===== rtl/sky_dp.sv =====
// datapath: skyline memory, prefix max memory, window max scan and result register
module sky_dp
  import sky_pkg::*;
#(
  parameter int ATLAS_SIZE = ATLAS_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sky_cmd_t          cmd_i,
  output sky_stat_t         stat_o,
  input  logic              req_type_i,
  input  logic [RECT_W-1:0] rect_width_i,
  input  logic [RECT_W-1:0] rect_height_i,
  output logic [POS_W-1:0]  pos_x_o,
  output logic [POS_W-1:0]  pos_y_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int AW = $clog2(ATLAS_SIZE);
  localparam int HW = $clog2(ATLAS_SIZE + 1);
  localparam int CW = ((HW > RECT_W) ? HW : RECT_W) + 1;

  logic [HW-1:0] mem_h [ATLAS_SIZE];
  logic [HW-1:0] mem_p [ATLAS_SIZE];

  logic              type_q;
  logic [RECT_W-1:0] w_q, h_q;
  logic [AW-1:0]     idx_q, blk_q, wr_last_q;
  logic              rd_v_q, rd_p2_q;
  logic [AW-1:0]     rd_idx_q, rd_blk_q;
  logic              rd_try_q;
  logic [HW-1:0]     hrd_q, prd_q, run_q, best_q;
  logic [AW-1:0]     bestx_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q;
  logic [STAT_W-1:0] status_q;

  logic [CW-1:0] w_c, wm1_c, h_c, top_c;
  logic [AW-1:0] p1_blk_nxt, p2_blk_nxt, paddr;
  logic          try_c, s_end;
  logic [HW-1:0] p_val, s_val, cand, fill;
  logic          h_wr;

  always_comb begin
    w_c        = CW'(w_q);
    h_c        = CW'(h_q);
    wm1_c      = w_c - CW'(1);
    top_c      = CW'(best_q) + h_c;
    fill       = HW'(top_c);
    p1_blk_nxt = (CW'(blk_q) == wm1_c) ? '0 : blk_q + AW'(1);
    p2_blk_nxt = (blk_q == '0) ? AW'(wm1_c) : blk_q - AW'(1);
    try_c      = (CW'(idx_q) + w_c) < CW'(ATLAS_SIZE);
    paddr      = AW'(CW'(idx_q) + wm1_c);
    // running max from the block start (left to right)
    if (rd_blk_q == '0) begin
      p_val = hrd_q;
    end else begin
      p_val = (hrd_q > run_q) ? hrd_q : run_q;
    end
    // running max to the block end (right to left)
    s_end = (CW'(rd_blk_q) == wm1_c) || (rd_idx_q == AW'(ATLAS_SIZE - 1));
    if (s_end) begin
      s_val = hrd_q;
    end else begin
      s_val = (hrd_q > run_q) ? hrd_q : run_q;
    end
    cand  = (s_val > prd_q) ? s_val : prd_q;
    h_wr  = cmd_i.clr_step || cmd_i.wr_step;
  end

  always_comb begin
    stat_o.req_clear = (type_q == REQ_CLEAR);
    stat_o.req_bad   = (w_q == '0) || (h_q == '0) || (w_c >= CW'(ATLAS_SIZE));
    stat_o.idx_top   = (idx_q == AW'(ATLAS_SIZE - 1));
    stat_o.idx_zero  = (idx_q == '0);
    stat_o.wr_end    = (idx_q == wr_last_q);
    stat_o.fits      = (top_c <= CW'(ATLAS_SIZE));
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      rd_v_q  <= 1'b0;
      rd_p2_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.p1_step || cmd_i.p2_step;
      rd_p2_q <= cmd_i.p2_step;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.p1_step || cmd_i.wr_step) begin
        idx_q <= idx_q + AW'(1);
      end else if (cmd_i.p2_init) begin
        idx_q <= AW'(ATLAS_SIZE - 1);
      end else if (cmd_i.p2_step) begin
        idx_q <= idx_q - AW'(1);
      end else if (cmd_i.wr_init) begin
        idx_q <= bestx_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_i;
      w_q    <= rect_width_i;
      h_q    <= rect_height_i;
      blk_q  <= '0;
    end else if (cmd_i.p1_step) begin
      blk_q <= p1_blk_nxt;
    end else if (cmd_i.p2_init) begin
      blk_q <= rd_blk_q;
    end else if (cmd_i.p2_step) begin
      blk_q <= p2_blk_nxt;
    end
    rd_idx_q <= idx_q;
    rd_blk_q <= blk_q;
    rd_try_q <= try_c;
    if (rd_v_q) begin
      run_q <= rd_p2_q ? s_val : p_val;
    end
    if (cmd_i.p2_init) begin
      best_q  <= HW'(ATLAS_SIZE);
      bestx_q <= '0;
    end else if (rd_v_q && rd_p2_q && rd_try_q && (cand <= best_q)) begin
      best_q  <= cand;
      bestx_q <= rd_idx_q;
    end
    if (cmd_i.wr_init) begin
      wr_last_q <= AW'(CW'(bestx_q) + wm1_c);
    end
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      if (cmd_i.out_status == ST_PLACED) begin
        pos_x_q <= POS_W'(bestx_q);
        pos_y_q <= POS_W'(best_q);
      end else begin
        pos_x_q <= '0;
        pos_y_q <= '0;
      end
    end
  end

  // skyline memory
  always_ff @(posedge clk_i) begin
    if (h_wr) begin
      mem_h[idx_q] <= cmd_i.clr_step ? '0 : fill;
    end
    hrd_q <= mem_h[idx_q];
  end

  // prefix max memory
  always_ff @(posedge clk_i) begin
    if (rd_v_q && !rd_p2_q) begin
      mem_p[rd_idx_q] <= p_val;
    end
    prd_q <= mem_p[paddr];
  end

  assign pos_x_o  = pos_x_q;
  assign pos_y_o  = pos_y_q;
  assign status_o = status_q;

endmodule

// ===== rtl/sky_ctrl.sv =====
// controller: sequences clear sweep, scan passes, skyline update and result hand-off
module sky_ctrl
  import sky_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sky_stat_t stat_i,
  output sky_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_P1     = 4'd3;
  localparam logic [3:0] S_P1_END = 4'd4;
  localparam logic [3:0] S_P2     = 4'd5;
  localparam logic [3:0] S_P2_END = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_WRITE  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state_q, state_d;
  logic              rep_q, rep_d;
  logic [STAT_W-1:0] res_q, res_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    rep_d       = rep_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.idx_top) begin
          if (rep_q) begin
            rep_d   = 1'b0;
            res_d   = ST_CLEARED;
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.req_clear) begin
          rep_d   = 1'b1;
          state_d = S_CLEAR;
        end else if (stat_i.req_bad) begin
          res_d   = ST_NOROOM;
          state_d = S_DONE;
        end else begin
          state_d = S_P1;
        end
      end
      S_P1: begin
        cmd_o.p1_step = 1'b1;
        if (stat_i.idx_top) begin
          state_d = S_P1_END;
        end
      end
      S_P1_END: begin
        cmd_o.p2_init = 1'b1;
        state_d       = S_P2;
      end
      S_P2: begin
        cmd_o.p2_step = 1'b1;
        if (stat_i.idx_zero) begin
          state_d = S_P2_END;
        end
      end
      S_P2_END: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.fits) begin
          cmd_o.wr_init = 1'b1;
          state_d       = S_WRITE;
        end else begin
          res_d   = ST_NOROOM;
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_step = 1'b1;
        if (stat_i.wr_end) begin
          res_d   = ST_PLACED;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = res_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rep_q       <= 1'b0;
      res_q       <= ST_NOROOM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rep_q       <= rep_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/skyline_atlas_allocator.sv =====
// top level of the skyline atlas allocator
// skyline packer for a square atlas of ATLAS_SIZE x ATLAS_SIZE texels
// - input channel (in_valid_i / in_stall_o): one item per request, req_type_i
//   selects allocate or clear, rect_width_i / rect_height_i give the size
// - output channel (out_valid_o / out_stall_i): exactly one item per request,
//   pos_x_o / pos_y_o and status_o (placed, no room, cleared)
// - one request is worked on at a time; a clear sweeps the skyline memory,
//   one memory row per cycle; an allocate runs the two scans over the
//   skyline memory (prefix max forward, suffix max backward, one column per
//   cycle) and then writes back the covered columns; a request with a bad
//   size returns no room without the scans
// - after reset the skyline memory is swept to zero, in_stall_o stays high
//   meanwhile and no result item is produced
// - a result waits in the output register while out_stall_i is high; the
//   next request is already taken and worked on, and its result waits
//   until the register has been emptied
module skyline_atlas_allocator
  import sky_pkg::*;
#(
  parameter int ATLAS_SIZE = ATLAS_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [RECT_W-1:0] rect_width_i,
  input  logic [RECT_W-1:0] rect_height_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [POS_W-1:0]  pos_x_o,
  output logic [POS_W-1:0]  pos_y_o,
  output logic [STAT_W-1:0] status_o
);

  sky_cmd_t  cmd;
  sky_stat_t stat;

  // sequencer: clear sweep, scans, write-back, output hand-off
  sky_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // skyline and prefix max memories, window max search, result payload
  sky_dp #(
    .ATLAS_SIZE(ATLAS_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_type_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .status_o     (status_o)
  );

`include "assert_macros.svh"

  // a taken item closes the input side on the next cycle
  `SKY_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // memory sweeps and scans only run while no item can be taken
  `SKY_ASSERT(a_work_while_busy,
    (cmd.clr_step || cmd.p1_step || cmd.p2_step || cmd.wr_step) |-> in_stall_o)

  // a waiting result is never overwritten
  `SKY_ASSERT(a_no_result_overwrite, cmd.out_load |-> !(out_valid_o && out_stall_i))

endmodule
